FILE: rtl/ppc_pkg.sv
// ---------------------------------------------------------------------------
// ppc_pkg
// Shared types, widths and register indexes of the positional PID controller.
// ---------------------------------------------------------------------------
package ppc_pkg;

   // sample and gain widths
   localparam int unsigned SampleWidth  = 16;
   localparam int unsigned GainWidth    = 16;
   localparam int unsigned ILimitWidth  = 23;
   localparam int unsigned OLimitWidth  = 15;
   localparam int unsigned SumWidth     = 32;
   localparam int unsigned ErrWidth     = SampleWidth + 1;
   localparam int unsigned DiffWidth    = ErrWidth + 1;

   // configuration port
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = ILimitWidth;

   // product and accumulator widths
   localparam int unsigned PropWidth  = GainWidth + ErrWidth;
   localparam int unsigned IntWidth   = GainWidth + SumWidth;
   localparam int unsigned DerWidth   = GainWidth + DiffWidth;
   localparam int unsigned AccWidth   = IntWidth + 1;
   localparam int unsigned FracBits   = 8;
   localparam int unsigned ShiftWidth = AccWidth - FracBits;

   // register indexes of the configuration port
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_GAIN_P          = 3'd0,
      CSR_GAIN_I          = 3'd1,
      CSR_GAIN_D          = 3'd2,
      CSR_INTEGRAL_LIMIT  = 3'd3,
      CSR_OUTPUT_LIMIT    = 3'd4,
      CSR_DERIVATIVE_MODE = 3'd5
   } csr_index_type;

   // derivative source select
   typedef enum logic {
      DMODE_ERROR_CHANGE = 1'b0,
      DMODE_RATE_INPUT   = 1'b1
   } dmode_type;

endpackage

FILE: rtl/positional_pid_controller_unit.sv
// ---------------------------------------------------------------------------
// positional_pid_controller_unit
// Positional PID with saturating error sum, integral clamp and output clamp.
// ---------------------------------------------------------------------------
// Pipeline: a request passes the input register, the product register and
// the result register before its result shows on rsp.
// Throughput: one request per cycle unless rsp stalls; the error sum update
// (add, saturate, one 16x32 multiply, bound compare) is combinational.
// Reset clears valid flags, configuration registers, error sum and previous
// error; no clearing pass, the block takes requests right after reset.
module positional_pid_controller_unit
   import ppc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request: setpoint [15:0], measured [31:16], rate [47:32]
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [3*SampleWidth-1:0]   req_tdata,
   // response: drive [15:0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [SampleWidth-1:0]     rsp_tdata,
   // configuration writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CsrIndexWidth-1:0]   csr_index,
   input  logic [CsrDataWidth-1:0]    csr_data
);

   // configuration registers
   logic signed [GainWidth-1:0]   gain_p_ff, gain_i_ff, gain_d_ff;
   logic        [ILimitWidth-1:0] ilimit_ff;
   logic        [OLimitWidth-1:0] olimit_ff;
   dmode_type                     dmode_ff;

   // state
   logic signed [SumWidth-1:0]    error_sum_ff, error_sum_in;
   logic signed [ErrWidth-1:0]    prev_error_ff, prev_error_in;

   // stage 0: input register
   logic                          s0_valid_ff;
   logic signed [SampleWidth-1:0] setpoint_ff, measured_ff, rate_ff;

   // stage 1: product register
   logic                          s1_valid_ff;
   logic signed [PropWidth-1:0]   prop_ff, prop_in;
   logic signed [IntWidth-1:0]    integ_ff, integ_in;
   logic signed [DerWidth-1:0]    deriv_ff, deriv_in;

   // stage 2: result register
   logic                          s2_valid_ff;
   logic signed [SampleWidth-1:0] drive_ff, drive_in;

   // pipeline flow
   logic s2_ready, s1_ready, s0_ready, s0_adv, s1_adv;

   assign s2_ready   = !s2_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign s0_ready   = !s0_valid_ff || s1_ready;
   assign s0_adv     = s0_valid_ff && s1_ready;
   assign s1_adv     = s1_valid_ff && s2_ready;
   assign req_tready = s0_ready;
   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = drive_ff;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         ilimit_ff <= '0;
         olimit_ff <= '0;
         dmode_ff  <= DMODE_ERROR_CHANGE;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:          gain_p_ff <= csr_data[GainWidth-1:0];
            CSR_GAIN_I:          gain_i_ff <= csr_data[GainWidth-1:0];
            CSR_GAIN_D:          gain_d_ff <= csr_data[GainWidth-1:0];
            CSR_INTEGRAL_LIMIT:  ilimit_ff <= csr_data[ILimitWidth-1:0];
            CSR_OUTPUT_LIMIT:    olimit_ff <= csr_data[OLimitWidth-1:0];
            CSR_DERIVATIVE_MODE: dmode_ff  <= dmode_type'(csr_data[0]);
            default: ;
         endcase
      end
   end

   // error and saturating sum
   logic signed [ErrWidth-1:0]   err;
   logic signed [SumWidth:0]     sum_raw;
   logic signed [SumWidth-1:0]   sum_sat;
   logic signed [SumWidth:0]     sum_max, sum_min;

   assign err     = ErrWidth'(setpoint_ff) - ErrWidth'(measured_ff);
   assign sum_raw = (SumWidth+1)'(error_sum_ff) + (SumWidth+1)'(err);
   assign sum_max = (SumWidth+1)'({1'b0, {(SumWidth-1){1'b1}}});
   assign sum_min = -sum_max - (SumWidth+1)'(1);

   always_comb begin
      if (sum_raw > sum_max)      sum_sat = sum_max[SumWidth-1:0];
      else if (sum_raw < sum_min) sum_sat = sum_min[SumWidth-1:0];
      else                        sum_sat = sum_raw[SumWidth-1:0];
   end

   // integral clamp: high test first, low test on the possibly updated sum
   logic signed [IntWidth-1:0] prod_sum, prod_lim, prod_mid, bound_s, limit_s;
   logic                       gi_nz, fire_hi, fire_lo;

   assign gi_nz    = (gain_i_ff != '0);
   assign limit_s  = IntWidth'(signed'({1'b0, ilimit_ff}));
   assign bound_s  = IntWidth'(signed'({1'b0, ilimit_ff, {FracBits{1'b0}}}));
   assign prod_sum = IntWidth'(gain_i_ff) * IntWidth'(sum_sat);
   assign prod_lim = IntWidth'(gain_i_ff) * limit_s;
   assign fire_hi  = gi_nz && (prod_sum > bound_s);
   assign prod_mid = fire_hi ? prod_lim : prod_sum;
   assign fire_lo  = gi_nz && (prod_mid < -bound_s);

   always_comb begin
      if (fire_lo) begin
         error_sum_in = -SumWidth'(limit_s);
         integ_in     = -prod_lim;
      end else if (fire_hi) begin
         error_sum_in = SumWidth'(limit_s);
         integ_in     = prod_lim;
      end else begin
         error_sum_in = sum_sat;
         integ_in     = prod_sum;
      end
   end

   // proportional and derivative products
   logic signed [DiffWidth-1:0] dterm;

   always_comb begin
      case (dmode_ff)
         DMODE_RATE_INPUT: dterm = DiffWidth'(rate_ff);
         default:          dterm = DiffWidth'(err) - DiffWidth'(prev_error_ff);
      endcase
   end

   assign prop_in       = PropWidth'(gain_p_ff) * PropWidth'(err);
   assign deriv_in      = DerWidth'(gain_d_ff) * DerWidth'(dterm);
   assign prev_error_in = err;

   // sum, floor shift and output clamp
   logic signed [AccWidth-1:0]   acc;
   logic signed [ShiftWidth-1:0] shifted, olim_s;

   assign acc     = AccWidth'(prop_ff) + AccWidth'(integ_ff) + AccWidth'(deriv_ff);
   assign shifted = ShiftWidth'(acc >>> FracBits);
   assign olim_s  = ShiftWidth'(signed'({1'b0, olimit_ff}));

   always_comb begin
      if (shifted < -olim_s)     drive_in = SampleWidth'(-olim_s);
      else if (shifted > olim_s) drive_in = SampleWidth'(olim_s);
      else                       drive_in = SampleWidth'(shifted);
   end

   // valid flags and state
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         error_sum_ff  <= '0;
         prev_error_ff <= '0;
      end else begin
         if (s0_ready) s0_valid_ff <= req_tvalid;
         if (s1_ready) s1_valid_ff <= s0_valid_ff;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s0_adv) begin
            error_sum_ff  <= error_sum_in;
            prev_error_ff <= prev_error_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s0_ready && req_tvalid) begin
         setpoint_ff <= req_tdata[SampleWidth-1:0];
         measured_ff <= req_tdata[2*SampleWidth-1:SampleWidth];
         rate_ff     <= req_tdata[3*SampleWidth-1:2*SampleWidth];
      end
      if (s0_adv) begin
         prop_ff  <= prop_in;
         integ_ff <= integ_in;
         deriv_ff <= deriv_in;
      end
      if (s1_adv) begin
         drive_ff <= drive_in;
      end
   end

   // checks
   a_drive_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) <= $signed({1'b0, olimit_ff})
                   && $signed(rsp_tdata) >= -$signed({1'b0, olimit_ff})))
      else $error("drive outside output clamp");

   a_no_clamp_zero_gi : assert property (@(posedge clock) disable iff (reset)
      (s0_adv && gain_i_ff == '0) |=> error_sum_ff == $past(sum_sat))
      else $error("error sum changed by clamp with zero integral gain");

   a_clamp_to_limit : assert property (@(posedge clock) disable iff (reset)
      (s0_adv && fire_hi) |=> (error_sum_ff == SumWidth'(limit_s)
                            || error_sum_ff == -SumWidth'(limit_s)))
      else $error("clamped error sum is not at the integral limit");

   a_sum_held_idle : assert property (@(posedge clock) disable iff (reset)
      !s0_adv |=> $stable(error_sum_ff))
      else $error("error sum moved without a request");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && error_sum_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

FILE: sim/positional_pid_controller_unit_tb.sv
// ---------------------------------------------------------------------------
// positional_pid_controller_unit_tb
// Self-checking bench for the positional PID controller. A short directed
// table covers reset behavior, gain and limit extremes, both derivative
// sources and the integral clamp ordering. A short wind-up run pushes the
// error sum up and down. Random samples under changing gains and
// back-pressure follow. Each drive value is checked against a cycle-free
// PID model kept in the bench, or against a value pinned in the table.
// ---------------------------------------------------------------------------
module positional_pid_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppc_pkg::*;

   localparam int     HoldCycles    = 64;
   localparam int     WatchdogLimit = 2000;
   localparam int     PhaseItems    = 55;
   localparam longint SumMax        = 64'sh7FFF_FFFF;
   localparam longint SumMin        = -64'sh8000_0000;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   // one step of the directed script: a register write or a sample
   typedef struct packed {
      row_kind_type       kind;
      csr_index_type      idx;
      logic [22:0]        wdata;
      logic signed [15:0] sp;
      logic signed [15:0] ms;
      logic signed [15:0] rt;
      logic               pinned;
      logic signed [15:0] pin;
   } script_row_type;

   typedef struct {
      logic               pinned;
      logic signed [15:0] value;
   } pinned_drive_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [3*SampleWidth-1:0]   req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [SampleWidth-1:0]     rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   csr_index_type              csr_index  = CSR_GAIN_P;
   logic [CsrDataWidth-1:0]    csr_data   = '0;

   // controller state and register copy
   logic signed [15:0] cfg_gain_p = '0;
   logic signed [15:0] cfg_gain_i = '0;
   logic signed [15:0] cfg_gain_d = '0;
   logic [22:0]        cfg_ilimit = '0;
   logic [14:0]        cfg_olimit = '0;
   dmode_type          cfg_dmode  = DMODE_ERROR_CHANGE;
   int                 err_sum    = 0;
   logic signed [16:0] prev_err   = '0;

   logic signed [15:0] drive_q [$];
   pinned_drive_type   pin_q [$];
   int                 fail_count = 0;
   int                 idle_run   = 0;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 hold_asks  = 0;
   int                 hold_seen  = 0;
   int                 hold_left  = 0;

   script_row_type script [0:36] = '{
      // reset state: zero output limit forces zero drive
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd32767, 16'sh8000, 16'sh8000, 1'b1, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sh8000, 16'sd32767, 16'sd32767, 1'b1, 16'sd0},
      // unity proportional gain, full output range
      '{ROW_CSR, CSR_GAIN_P, 23'd256, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_OUTPUT_LIMIT, 23'd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd100, 16'sd40, 16'sd0, 1'b1, 16'sd60},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd32767, 16'sh8000, 16'sd0, 1'b1, 16'sd32767},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sh8000, 16'sd32767, 16'sd0, 1'b1, -16'sd32767},
      // floor rounding of the fraction shift
      '{ROW_CSR, CSR_GAIN_P, 23'd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd0, 16'sd1, 16'sd0, 1'b1, -16'sd1},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd0, -16'sd1, 16'sd0, 1'b1, 16'sd0},
      // extreme gains, derivative from error change
      '{ROW_CSR, CSR_GAIN_P, 23'h00_8000, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_GAIN_D, 23'd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd32767, 16'sh8000, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sh8000, 16'sd32767, 16'sd0, 1'b0, 16'sd0},
      // derivative from rate input
      '{ROW_CSR, CSR_GAIN_P, 23'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_GAIN_D, 23'h00_8000, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_DERIVATIVE_MODE, 23'(DMODE_RATE_INPUT),
        16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1, -16'sd32767},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd0, 16'sd0, 16'sh8000, 1'b1, 16'sd32767},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd5, 16'sd3, -16'sd1, 1'b1, 16'sd128},
      // integral clamp to the positive and negative bound
      '{ROW_CSR, CSR_GAIN_D, 23'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_DERIVATIVE_MODE, 23'(DMODE_ERROR_CHANGE),
        16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_GAIN_I, 23'd256, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_INTEGRAL_LIMIT, 23'd100, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd1000, 16'sd0, 16'sd0, 1'b1, 16'sd100},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, -16'sd1000, 16'sd0, 16'sd0, 1'b1, -16'sd100},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, -16'sd100},
      // negative gain: upper clamp then lower clamp on the same sample
      '{ROW_CSR, CSR_GAIN_I, 23'h00_FE00, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, -16'sd10, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      // zero and full integral bound
      '{ROW_CSR, CSR_INTEGRAL_LIMIT, 23'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd7, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_INTEGRAL_LIMIT, 23'h7F_FFFF, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_GAIN_I, 23'd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd32767, 16'sh8000, 16'sd0, 1'b0, 16'sd0},
      // zero output limit under maximum gain
      '{ROW_CSR, CSR_OUTPUT_LIMIT, 23'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_CSR, CSR_GAIN_P, 23'd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, CSR_GAIN_P, 23'd0, 16'sd32767, 16'sh8000, 16'sd32767, 1'b1, 16'sd0}
   };

   positional_pid_controller_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // one PID step: update error sum and previous error, return the drive
   function automatic logic signed [15:0] pid_update(logic signed [15:0] sp,
                                                     logic signed [15:0] ms,
                                                     logic signed [15:0] rt);
      longint e, sum, bnd, dv, acc, y, olim;
      e   = longint'(sp) - longint'(ms);
      sum = longint'(err_sum) + e;
      if (sum > SumMax) sum = SumMax;
      if (sum < SumMin) sum = SumMin;
      bnd = longint'(cfg_ilimit) * 256;
      // clamp tests run in order, the second one sees the updated sum
      if (cfg_gain_i != 0) begin
         if (longint'(cfg_gain_i) * sum > bnd) sum = longint'(cfg_ilimit);
         if (longint'(cfg_gain_i) * sum < -bnd) sum = -longint'(cfg_ilimit);
      end
      err_sum = int'(sum);
      dv = (cfg_dmode == DMODE_RATE_INPUT) ? longint'(rt) : e - longint'(prev_err);
      acc = longint'(cfg_gain_p) * e + longint'(cfg_gain_i) * sum
          + longint'(cfg_gain_d) * dv;
      y = acc >>> 8;
      prev_err = 17'(e);
      olim = longint'(cfg_olimit);
      if (y < -olim) y = -olim;
      if (y > olim) y = olim;
      return 16'(y);
   endfunction

   function automatic logic signed [15:0] pick_gain();
      case ($urandom_range(5))
         0: return 16'sd32767;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'(int'($urandom_range(1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // mix of extreme, near-balanced and fully random samples
   function automatic void random_sample(output logic signed [15:0] sp,
                                         output logic signed [15:0] ms,
                                         output logic signed [15:0] rt);
      int base;
      rt = 16'($urandom);
      case ($urandom_range(19))
         0, 1, 2: begin
            sp = $urandom_range(1) ? 16'sd32767 : 16'sh8000;
            ms = $urandom_range(1) ? 16'sd32767 : 16'sh8000;
         end
         3, 4, 5, 6, 7, 8: begin
            base = int'($urandom_range(60000)) - 30000;
            sp   = 16'(base);
            ms   = 16'(base + int'($urandom_range(400)) - 200);
         end
         default: begin
            sp = 16'($urandom);
            ms = 16'($urandom);
         end
      endcase
   endfunction

   task automatic csr_write(csr_index_type idx, logic [22:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic offer_sample(logic signed [15:0] sp, logic signed [15:0] ms,
                               logic signed [15:0] rt, logic pinned,
                               logic signed [15:0] pin);
      pin_q.push_back('{pinned, pin});
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rt, ms, sp};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait for every pending drive value
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (drive_q.size() != 0) @(posedge clock);
   endtask

   // kind 0 all maximum, kind 1 minimum gains, otherwise random
   task automatic write_settings(int kind);
      logic signed [15:0] gp, gi, gd;
      logic [22:0]        il;
      logic [14:0]        ol;
      dmode_type          dm;
      if (kind == 0) begin
         gp = 16'sd32767; gi = 16'sd32767; gd = 16'sd32767;
         il = 23'h7F_FFFF; ol = 15'h7FFF; dm = DMODE_RATE_INPUT;
      end else if (kind == 1) begin
         gp = 16'sh8000; gi = 16'sh8000; gd = 16'sh8000;
         il = 23'd0; ol = 15'h7FFF; dm = DMODE_ERROR_CHANGE;
      end else begin
         gp = pick_gain();
         gi = pick_gain();
         gd = pick_gain();
         case ($urandom_range(3))
            0: il = 23'd0;
            1: il = 23'h7F_FFFF;
            2: il = 23'($urandom_range(4000));
            default: il = 23'($urandom);
         endcase
         case ($urandom_range(4))
            0: ol = 15'd0;
            1: ol = 15'h7FFF;
            2: ol = 15'($urandom_range(2000));
            default: ol = 15'($urandom);
         endcase
         dm = dmode_type'($urandom_range(1));
      end
      csr_write(CSR_GAIN_P, {7'd0, gp});
      csr_write(CSR_GAIN_I, {7'd0, gi});
      csr_write(CSR_GAIN_D, {7'd0, gd});
      csr_write(CSR_INTEGRAL_LIMIT, il);
      csr_write(CSR_OUTPUT_LIMIT, {8'd0, ol});
      csr_write(CSR_DERIVATIVE_MODE, 23'(dm));
      csr_valid <= 1'b0;
   endtask

   // response side: random stalls plus a single long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_asks != hold_seen) begin
         hold_seen  <= hold_asks;
         hold_left  <= HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // predict on each accepted request, check each accepted response
   always @(posedge clock) begin : monitor
      logic signed [15:0] want, model;
      pinned_drive_type   pd;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (drive_q.size() == 0) begin
               $display("%0t: drive expected none, got %0d", $time, $signed(rsp_tdata));
               fail_count++;
            end else begin
               want = drive_q.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: drive expected %0d, got %0d",
                           $time, want, $signed(rsp_tdata));
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pd    = pin_q.pop_front();
            model = pid_update(req_tdata[15:0], req_tdata[31:16], req_tdata[47:32]);
            drive_q.push_back(pd.pinned ? pd.value : model);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN_P:          cfg_gain_p = csr_data[15:0];
               CSR_GAIN_I:          cfg_gain_i = csr_data[15:0];
               CSR_GAIN_D:          cfg_gain_d = csr_data[15:0];
               CSR_INTEGRAL_LIMIT:  cfg_ilimit = csr_data[22:0];
               CSR_OUTPUT_LIMIT:    cfg_olimit = csr_data[14:0];
               CSR_DERIVATIVE_MODE: cfg_dmode  = dmode_type'(csr_data[0]);
               default: ;
            endcase
         end
         // watchdog on cycles with no transfer anywhere
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)
             || (csr_valid && csr_ready)) begin
            idle_run = 0;
         end else begin
            idle_run++;
         end
         if (idle_run >= WatchdogLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int                 phase, s, n, seg;
      logic signed [15:0] sp, ms, rt;
      int                 wind_len [4] = '{12, 8, 12, 4};
      logic               wind_up  [4] = '{1'b1, 1'b0, 1'b0, 1'b1};
      int                 send_pct_by_phase  [4] = '{0, 87, 0, 28};
      int                 stall_pct_by_phase [4] = '{0, 0, 87, 28};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script
      foreach (script[r]) begin
         if (script[r].kind == ROW_CSR) begin
            settle();
            csr_write(script[r].idx, script[r].wdata);
            csr_valid <= 1'b0;
         end else begin
            offer_sample(script[r].sp, script[r].ms, script[r].rt,
                         script[r].pinned, script[r].pin);
         end
      end

      // wind-up: push the error sum high, walk back, push it low, walk back
      settle();
      csr_write(CSR_GAIN_P, 23'd0);
      csr_write(CSR_GAIN_I, 23'd0);
      csr_write(CSR_GAIN_D, 23'd0);
      csr_write(CSR_OUTPUT_LIMIT, 23'd32767);
      csr_write(CSR_DERIVATIVE_MODE, 23'($urandom_range(1)));
      csr_valid <= 1'b0;
      for (seg = 0; seg < 4; seg++) begin
         for (n = 0; n < wind_len[seg]; n++) begin
            offer_sample(wind_up[seg] ? 16'sd32767 : 16'sh8000,
                         wind_up[seg] ? 16'sh8000 : 16'sd32767,
                         16'($urandom), 1'b0, 16'sd0);
         end
      end
      // expose the remaining sum through a modest integral gain
      settle();
      csr_write(CSR_GAIN_I, 23'd128);
      csr_write(CSR_INTEGRAL_LIMIT, 23'h7F_FFFF);
      csr_valid <= 1'b0;
      for (n = 0; n < 16; n++) begin
         random_sample(sp, ms, rt);
         offer_sample(sp, ms, rt, 1'b0, 16'sd0);
      end

      // random phases under different idle patterns
      for (phase = 0; phase < 4; phase++) begin
         for (s = 0; s < 2; s++) begin
            settle();
            write_settings(phase * 2 + s);
            send_idle_pct = send_pct_by_phase[phase];
            recv_stall_pct <= stall_pct_by_phase[phase];
            if (phase == 0 && s == 0) hold_asks <= hold_asks + 1;
            for (n = 0; n < PhaseItems; n++) begin
               random_sample(sp, ms, rt);
               offer_sample(sp, ms, rt, 1'b0, 16'sd0);
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/ppc_pkg.sv
rtl/positional_pid_controller_unit.sv
sim/positional_pid_controller_unit_tb.sv
